// ===== rtl/pesr_pkg.sv =====
`timescale 1ns / 1ps
package pesr_pkg;

   localparam int COORD_W = 31;
   localparam int LEN_W = 32;
   localparam int PROD_W = 64;
   localparam int FIFO_DEPTH = 2;

   typedef logic signed [COORD_W-1:0] coord_type;

   // The front end tags each vertex; the back end still restarts a path on a
   // segment vertex that arrives while no path is open.
   typedef enum logic {
      KIND_START,
      KIND_SEGMENT
   } kind_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
      logic      last;
      kind_type  kind;
   } item_type;

   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [LEN_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] quotient;
      logic [LEN_W-1:0]  remainder;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ECHO,
      ST_DIFF,
      ST_SQ_MUL,
      ST_SQ_ACC,
      ST_SQRT,
      ST_LEN,
      ST_MOD_WAIT,
      ST_PT_MUL,
      ST_PT_DIV,
      ST_PT_WAIT,
      ST_PT_EMIT,
      ST_TAIL,
      ST_OUT
   } back_state_type;

endpackage

// ===== rtl/pesr_req_if.sv =====
`timescale 1ns / 1ps
interface pesr_req_if import pesr_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type pos_x;
   coord_type pos_y;
   coord_type pos_z;
   logic      first_vertex;
   logic      last_vertex;

   modport source (output valid, pos_x, pos_y, pos_z, first_vertex, last_vertex,
                   input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, first_vertex, last_vertex,
                 output ready);
endinterface

// ===== rtl/pesr_rsp_if.sv =====
`timescale 1ns / 1ps
interface pesr_rsp_if import pesr_pkg::*; ();
   logic      valid;
   logic      ready;
   coord_type out_x;
   coord_type out_y;
   coord_type out_z;
   logic      end_of_run;
   logic      end_of_path;
   logic      truncated;

   modport source (output valid, out_x, out_y, out_z, end_of_run, end_of_path, truncated,
                   input ready);
   modport sink (input valid, out_x, out_y, out_z, end_of_run, end_of_path, truncated,
                 output ready);
endinterface

// ===== rtl/pesr_front.sv =====
`timescale 1ns / 1ps
module pesr_front import pesr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   pesr_req_if.sink  req_ch,
   output logic      item_valid,
   output item_type  item,
   input  logic      item_pop
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);

   item_type              mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]        count_ff, count_in;
   logic                  push;
   logic                  pop;
   item_type              new_item;

   assign req_ch.ready = (count_ff != (PTR_W+1)'(FIFO_DEPTH));
   assign push = req_ch.valid && req_ch.ready;
   assign pop = item_pop && item_valid;
   assign item_valid = (count_ff != '0);
   assign item = mem_ff[rd_ptr_ff];

   always_comb begin
      new_item.x = req_ch.pos_x;
      new_item.y = req_ch.pos_y;
      new_item.z = req_ch.pos_z;
      new_item.last = req_ch.last_vertex;
      new_item.kind = req_ch.first_vertex ? KIND_START : KIND_SEGMENT;
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ===== rtl/pesr_div.sv =====
`timescale 1ns / 1ps
module pesr_div import pesr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   // Restoring divider, one quotient bit per cycle; the quotient shifts into
   // the dividend register as the dividend shifts out.
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic [PROD_W-1:0]    dvd_ff, dvd_in;
   logic [LEN_W-1:0]     rem_ff, rem_in;
   logic [LEN_W-1:0]     dvs_ff, dvs_in;
   logic [LEN_W:0]       shifted;
   logic [LEN_W:0]       trial;
   logic                 ge;

   assign shifted = {rem_ff, dvd_ff[PROD_W-1]};
   assign trial = shifted - {1'b0, dvs_ff};
   assign ge = (shifted >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (busy_ff) begin
         dvd_in = {dvd_ff[PROD_W-2:0], ge};
         rem_in = ge ? trial[LEN_W-1:0] : shifted[LEN_W-1:0];
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         dvd_in = div_req.dividend;
         rem_in = '0;
         dvs_in = div_req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   always_comb begin
      div_rsp.done = done_ff;
      div_rsp.quotient = dvd_ff;
      div_rsp.remainder = rem_ff;
   end

endmodule

// ===== rtl/pesr_back.sv =====
`timescale 1ns / 1ps
module pesr_back import pesr_pkg::*; #(
   parameter int MAX_POINTS_PER_VERTEX = 63,
   parameter int FRACTION_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  item_type          item,
   output logic              item_pop,
   input  logic              csr_wr_en,
   input  logic [COORD_W-1:0] csr_wr_data,
   output div_req_type       div_req,
   input  div_rsp_type       div_rsp,
   pesr_rsp_if.source        rsp_ch
);

   localparam int CNT_W = $clog2(MAX_POINTS_PER_VERTEX + 1);
   localparam logic [COORD_W-1:0] SEG_RESET = COORD_W'(60 << FRACTION_BITS);
   localparam logic [PROD_W-1:0] SQRT_TOP = PROD_W'(1) << (PROD_W - 2);

   logic [COORD_W-1:0]   seg_ff;
   logic [LEN_W-1:0]     seg_eff;

   back_state_type       state_ff, state_in;
   back_state_type       ret_ff, ret_in;
   item_type             cur_ff, cur_in;
   coord_type            prev_ff [3];
   coord_type            prev_in [3];
   coord_type            emit_ff [3];
   coord_type            emit_in [3];
   coord_type            pt_ff [3];
   coord_type            pt_in [3];
   logic [LEN_W-1:0]     mag_ff [3];
   logic [LEN_W-1:0]     mag_in [3];
   logic                 neg_ff [3];
   logic                 neg_in [3];
   logic [LEN_W-1:0]     rem_ff, rem_in;
   logic                 open_ff, open_in;
   logic [1:0]           axis_ff, axis_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [PROD_W-1:0]    acc_ff, acc_in;
   logic [PROD_W-1:0]    v_ff, v_in;
   logic [PROD_W-1:0]    res_ff, res_in;
   logic [PROD_W-1:0]    bit_ff, bit_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [LEN_W-1:0]     off_ff, off_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 trunc_ff, trunc_in;

   logic                 out_valid_ff, out_valid_in;
   coord_type            out_x_ff, out_x_in;
   coord_type            out_y_ff, out_y_in;
   coord_type            out_z_ff, out_z_in;
   logic                 out_eor_ff, out_eor_in;
   logic                 out_eop_ff, out_eop_in;
   logic                 out_trunc_ff, out_trunc_in;

   logic [LEN_W-1:0]     r0;
   logic [LEN_W-1:0]     mul_b;
   logic [PROD_W-1:0]    sq_sum;
   logic [PROD_W-1:0]    sq_trial;
   logic [LEN_W:0]       lerp;
   logic                 final_pt;
   logic                 append;
   logic                 cur_differs;
   logic signed [LEN_W-1:0] diff [3];
   coord_type            cur_c [3];

   assign seg_eff = (seg_ff == '0) ? LEN_W'(1) : {1'b0, seg_ff};
   assign r0 = (rem_ff == '0) ? LEN_W'(1) : rem_ff;
   assign mul_b = (state_ff == ST_SQ_MUL) ? mag_ff[axis_ff] : off_ff;
   assign sq_sum = acc_ff + prod_ff;
   assign sq_trial = res_ff + bit_ff;
   assign cur_c[0] = cur_ff.x;
   assign cur_c[1] = cur_ff.y;
   assign cur_c[2] = cur_ff.z;
   assign cur_differs = (cur_ff.x != emit_ff[0]) || (cur_ff.y != emit_ff[1]) ||
                        (cur_ff.z != emit_ff[2]);
   assign final_pt = (cnt_ff == CNT_W'(1));
   assign append = cur_ff.last && ((cur_ff.x != pt_ff[0]) || (cur_ff.y != pt_ff[1]) ||
                                   (cur_ff.z != pt_ff[2]));
   assign lerp = neg_ff[axis_ff]
                 ? {prev_ff[axis_ff][COORD_W-1], prev_ff[axis_ff][COORD_W-1],
                    prev_ff[axis_ff]} - {1'b0, div_rsp.quotient[LEN_W-1:0]}
                 : {prev_ff[axis_ff][COORD_W-1], prev_ff[axis_ff][COORD_W-1],
                    prev_ff[axis_ff]} + {1'b0, div_rsp.quotient[LEN_W-1:0]};

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         diff[a] = {cur_c[a][COORD_W-1], cur_c[a]} -
                   {prev_ff[a][COORD_W-1], prev_ff[a]};
      end
   end

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      cur_in = cur_ff;
      prev_in = prev_ff;
      emit_in = emit_ff;
      pt_in = pt_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      rem_in = rem_ff;
      open_in = open_ff;
      axis_in = axis_ff;
      prod_in = prod_ff;
      acc_in = acc_ff;
      v_in = v_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      len_in = len_ff;
      off_in = off_ff;
      cnt_in = cnt_ff;
      trunc_in = trunc_ff;
      out_valid_in = out_valid_ff;
      out_x_in = out_x_ff;
      out_y_in = out_y_ff;
      out_z_in = out_z_ff;
      out_eor_in = out_eor_ff;
      out_eop_in = out_eop_ff;
      out_trunc_in = out_trunc_ff;
      item_pop = 1'b0;
      div_req.start = 1'b0;
      div_req.dividend = {{(PROD_W-LEN_W){1'b0}}, len_ff - r0};
      div_req.divisor = seg_eff;

      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               cur_in = item;
               state_in = (item.kind == KIND_START || !open_ff) ? ST_ECHO : ST_DIFF;
            end
         end
         ST_ECHO: begin
            out_valid_in = 1'b1;
            out_x_in = cur_ff.x;
            out_y_in = cur_ff.y;
            out_z_in = cur_ff.z;
            out_eor_in = 1'b1;
            out_eop_in = cur_ff.last;
            out_trunc_in = 1'b0;
            emit_in = cur_c;
            prev_in = cur_c;
            rem_in = seg_eff;
            open_in = !cur_ff.last;
            ret_in = ST_IDLE;
            state_in = ST_OUT;
         end
         ST_DIFF: begin
            for (int a = 0; a < 3; a++) begin
               neg_in[a] = diff[a][LEN_W-1];
               mag_in[a] = diff[a][LEN_W-1] ? LEN_W'(-diff[a]) : LEN_W'(diff[a]);
            end
            acc_in = '0;
            axis_in = '0;
            trunc_in = 1'b0;
            state_in = ST_SQ_MUL;
         end
         ST_SQ_MUL: begin
            prod_in = mag_ff[axis_ff] * mul_b;
            state_in = ST_SQ_ACC;
         end
         ST_SQ_ACC: begin
            acc_in = sq_sum;
            if (axis_ff == 2'd2) begin
               v_in = sq_sum;
               res_in = '0;
               bit_in = SQRT_TOP;
               state_in = ST_SQRT;
            end else begin
               axis_in = axis_ff + 2'd1;
               state_in = ST_SQ_MUL;
            end
         end
         ST_SQRT: begin
            // Two radicand bits per cycle, one root bit.
            if (v_ff >= sq_trial) begin
               v_in = v_ff - sq_trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if ((bit_ff >> 2) == '0) begin
               state_in = ST_LEN;
            end
            len_in = res_in[LEN_W-1:0];
         end
         ST_LEN: begin
            if (len_ff >= r0) begin
               div_req.start = 1'b1;
               state_in = ST_MOD_WAIT;
            end else begin
               rem_in = r0 - len_ff;
               state_in = ST_TAIL;
            end
         end
         ST_MOD_WAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient >= PROD_W'(MAX_POINTS_PER_VERTEX)) begin
                  trunc_in = 1'b1;
                  cnt_in = CNT_W'(MAX_POINTS_PER_VERTEX);
               end else begin
                  cnt_in = div_rsp.quotient[CNT_W-1:0] + CNT_W'(1);
               end
               rem_in = seg_eff - div_rsp.remainder;
               off_in = r0;
               axis_in = '0;
               state_in = ST_PT_MUL;
            end
         end
         ST_PT_MUL: begin
            prod_in = mag_ff[axis_ff] * mul_b;
            state_in = ST_PT_DIV;
         end
         ST_PT_DIV: begin
            div_req.start = 1'b1;
            div_req.dividend = prod_ff;
            div_req.divisor = len_ff;
            state_in = ST_PT_WAIT;
         end
         ST_PT_WAIT: begin
            if (div_rsp.done) begin
               pt_in[axis_ff] = lerp[COORD_W-1:0];
               if (axis_ff == 2'd2) begin
                  state_in = ST_PT_EMIT;
               end else begin
                  axis_in = axis_ff + 2'd1;
                  state_in = ST_PT_MUL;
               end
            end
         end
         ST_PT_EMIT: begin
            out_valid_in = 1'b1;
            out_x_in = pt_ff[0];
            out_y_in = pt_ff[1];
            out_z_in = pt_ff[2];
            out_eor_in = final_pt && !append;
            out_eop_in = final_pt && !append && cur_ff.last;
            out_trunc_in = trunc_ff;
            emit_in = pt_ff;
            cnt_in = cnt_ff - CNT_W'(1);
            off_in = off_ff + seg_eff;
            axis_in = '0;
            ret_in = final_pt ? ST_TAIL : ST_PT_MUL;
            state_in = ST_OUT;
         end
         ST_TAIL: begin
            prev_in = cur_c;
            state_in = ST_IDLE;
            if (cur_ff.last) begin
               open_in = 1'b0;
               if (cur_differs) begin
                  out_valid_in = 1'b1;
                  out_x_in = cur_ff.x;
                  out_y_in = cur_ff.y;
                  out_z_in = cur_ff.z;
                  out_eor_in = 1'b1;
                  out_eop_in = 1'b1;
                  out_trunc_in = trunc_ff;
                  emit_in = cur_c;
                  ret_in = ST_IDLE;
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (rsp_ch.ready) begin
               out_valid_in = 1'b0;
               state_in = ret_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= SEG_RESET;
      end else if (csr_wr_en) begin
         seg_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
         open_ff <= 1'b0;
         rem_ff <= '0;
         prev_ff <= '{default: '0};
         emit_ff <= '{default: '0};
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
         out_valid_ff <= out_valid_in;
         open_ff <= open_in;
         rem_ff <= rem_in;
         prev_ff <= prev_in;
         emit_ff <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      pt_ff <= pt_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      axis_ff <= axis_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      v_ff <= v_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      len_ff <= len_in;
      off_ff <= off_in;
      cnt_ff <= cnt_in;
      trunc_ff <= trunc_in;
      out_x_ff <= out_x_in;
      out_y_ff <= out_y_in;
      out_z_ff <= out_z_in;
      out_eor_ff <= out_eor_in;
      out_eop_ff <= out_eop_in;
      out_trunc_ff <= out_trunc_in;
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.out_x = out_x_ff;
   assign rsp_ch.out_y = out_y_ff;
   assign rsp_ch.out_z = out_z_ff;
   assign rsp_ch.end_of_run = out_eor_ff;
   assign rsp_ch.end_of_path = out_eop_ff;
   assign rsp_ch.truncated = out_trunc_ff;

endmodule

// ===== rtl/polyline_equal_spacing_resampler.sv =====
`timescale 1ns / 1ps
// Channel   Dir   Payload                                         Transaction
// req_ch    in    pos_x/y/z, first_vertex, last_vertex            valid & ready
// rsp_ch    out   out_x/y/z, end_of_run, end_of_path, truncated   valid & ready
// csr       in    csr_wr_data = segment_length                    csr_wr_en
//
// A first vertex is echoed to the output. A later vertex goes through the
// squared length and the 32-step square root, then the spacing remainder,
// and then three divisions per placed point on the one shared serial
// divider. A two-entry queue takes vertices while the back end works. Reset
// is synchronous and needs no clearing pass. Each result waits in the output
// register until taken, which stalls the back end only.
module polyline_equal_spacing_resampler import pesr_pkg::*; #(
   parameter int MAX_POINTS_PER_VERTEX = 63,
   parameter int FRACTION_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   pesr_req_if.sink           req_ch,
   pesr_rsp_if.source         rsp_ch,
   input  logic               csr_wr_en,
   input  logic [COORD_W-1:0] csr_wr_data
);

   logic        item_valid;
   item_type    item;
   logic        item_pop;
   div_req_type div_req;
   div_rsp_type div_rsp;

   pesr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   pesr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   pesr_back #(
      .MAX_POINTS_PER_VERTEX (MAX_POINTS_PER_VERTEX),
      .FRACTION_BITS         (FRACTION_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item        (item),
      .item_pop    (item_pop),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .div_req     (div_req),
      .div_rsp     (div_rsp),
      .rsp_ch      (rsp_ch)
   );

endmodule

// ===== rtl/pesr_checker.sv =====
`timescale 1ns / 1ps
module pesr_checker import pesr_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input coord_type out_x,
   input coord_type out_y,
   input coord_type out_z,
   input logic      end_of_run,
   input logic      end_of_path
);

   // A stalled transaction keeps its point.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_x) && $stable(out_y) &&
                                  $stable(out_z))
      else $error("rsp payload changed while stalled");

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_path_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && end_of_path |-> end_of_run)
      else $error("end_of_path without end_of_run");

endmodule

bind polyline_equal_spacing_resampler pesr_checker u_pesr_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .out_x       (rsp_ch.out_x),
   .out_y       (rsp_ch.out_y),
   .out_z       (rsp_ch.out_z),
   .end_of_run  (rsp_ch.end_of_run),
   .end_of_path (rsp_ch.end_of_path)
);
